>>> rtl/core/sitd_pkg.sv
// Shared types and constants for the signed integer to decimal text block.
package sitd_pkg;

  // ASCII codes of the characters the block emits.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Width of the minimum field width input.
  localparam int unsigned WIDTH_BITS = 6;

  // Which character the output register loads.
  typedef enum logic [1:0] {
    SEL_SPACE = 2'd0,
    SEL_MINUS = 2'd1,
    SEL_DIGIT = 2'd2
  } out_sel_e;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_CONV    = 6'b000010,
    ST_MEASURE = 6'b000100,
    ST_PAD     = 6'b001000,
    ST_SIGN    = 6'b010000,
    ST_DIGIT   = 6'b100000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;     // capture a new request
    logic     shift;    // one shift-add-3 step
    logic     measure;  // count digits and work out the padding
    logic     emit;     // load the output register
    out_sel_e sel;      // character to load on emit
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pad_zero;    // no padding left
    logic neg;         // value is negative
    logic digit_last;  // next digit is the least significant one
  } status_t;

endpackage

>>> rtl/core/signed_int_to_decimal_text_top.sv
// Top level of the signed integer to right-justified decimal text converter.
//
// Usage: each request on the slave stream carries a signed value and a
// minimum field width. The block answers with a run of ASCII characters on
// the master stream, one per transfer, most significant first: leading
// spaces up to the width, a minus sign for negative values, then the
// digits. tlast marks the final character of each run.
// Timing: once the request is taken, binary to BCD conversion runs
// shift-add-3 at one input bit per cycle, then a measure state counts the
// digits and works out the padding, and the padding state follows.
// Characters leave at one per cycle while the receiver takes them, with a
// break where the padding state closes. The conversion register set is
// shared, so one request is in work at a time.
// The next request is accepted as soon as the last character sits in the
// output register, even if the receiver has not taken it yet.
// Reset: asynchronous, active low; the block returns to idle and drops any
// pending output. Receiver stall: the output register holds its character
// and the controller waits until it drains.
module signed_int_to_decimal_text_top
  import sitd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned InW = ((VALUE_BITS + WIDTH_BITS + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [InW-1:0] s_axis_tdata_i,   // value, min_width, zero fill
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [7:0]     m_axis_tdata_o,   // character
  output logic           m_axis_tlast_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  sitd_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Conversion and output datapath.
  sitd_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .value_i    (s_axis_tdata_i[VALUE_BITS-1:0]),
    .min_width_i(s_axis_tdata_i[VALUE_BITS +: WIDTH_BITS]),
    .cmd_i      (cmd),
    .status_o   (status),
    .character_o(m_axis_tdata_o),
    .last_o     (m_axis_tlast_o)
  );

endmodule

>>> rtl/core/sitd_datapath.sv
// Datapath: magnitude, binary to BCD conversion, padding count and output register.
module sitd_datapath
  import sitd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [WIDTH_BITS-1:0] min_width_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic [7:0]            character_o,
  output logic                  last_o
);

  // Enough decimal digits for the magnitude 2^(VALUE_BITS-1).
  localparam int unsigned NDIG  = (VALUE_BITS * 3) / 10 + 1;
  localparam int unsigned IDX_W = $clog2(NDIG);
  localparam int unsigned LEN_W = WIDTH_BITS + 1;

  logic [VALUE_BITS-1:0] mag_q;
  logic                  neg_q;
  logic [WIDTH_BITS-1:0] width_q;
  logic [3:0]            digit_q [NDIG];
  logic [IDX_W-1:0]      idx_q;
  logic [WIDTH_BITS-1:0] pad_q;
  logic [7:0]            char_q;
  logic                  last_q;

  logic [VALUE_BITS-1:0] mag_in;
  logic [3:0]            adj   [NDIG];
  logic [3:0]            shifted [NDIG];
  logic [IDX_W-1:0]      top_idx;
  logic [LEN_W-1:0]      text_len;
  logic [LEN_W-1:0]      width_ext;
  logic [WIDTH_BITS-1:0] pad_calc;

  // Two's complement magnitude; the most negative value maps to 2^(VALUE_BITS-1).
  assign mag_in = value_i[VALUE_BITS-1]
                ? (~value_i) + {{(VALUE_BITS-1){1'b0}}, 1'b1}
                : value_i;

  // Shift-add-3 step: correct each BCD digit, then shift the magnitude in.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (digit_q[i] >= 4'd5) ? digit_q[i] + 4'd3 : digit_q[i];
    end
    shifted[0] = {adj[0][2:0], mag_q[VALUE_BITS-1]};
    for (int i = 1; i < NDIG; i++) begin
      shifted[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // Highest nonzero digit; zero still counts as one digit.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (digit_q[i] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  // Text length and the number of leading spaces.
  assign text_len  = LEN_W'(top_idx) + LEN_W'(1) + LEN_W'(neg_q);
  assign width_ext = LEN_W'(width_q);
  assign pad_calc  = (width_ext > text_len) ? WIDTH_BITS'(width_ext - text_len) : '0;

  // Conversion and counting registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q   <= mag_in;
      neg_q   <= value_i[VALUE_BITS-1];
      width_q <= min_width_i;
      for (int i = 0; i < NDIG; i++) begin
        digit_q[i] <= 4'd0;
      end
    end else if (cmd_i.shift) begin
      mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
      for (int i = 0; i < NDIG; i++) begin
        digit_q[i] <= shifted[i];
      end
    end
    if (cmd_i.measure) begin
      idx_q <= top_idx;
      pad_q <= pad_calc;
    end else if (cmd_i.emit) begin
      if (cmd_i.sel == SEL_SPACE) begin
        pad_q <= pad_q - WIDTH_BITS'(1);
      end
      if (cmd_i.sel == SEL_DIGIT) begin
        idx_q <= idx_q - IDX_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.sel)
        SEL_SPACE: begin
          char_q <= CH_SPACE;
          last_q <= 1'b0;
        end
        SEL_MINUS: begin
          char_q <= CH_MINUS;
          last_q <= 1'b0;
        end
        SEL_DIGIT: begin
          char_q <= CH_ZERO | {4'd0, digit_q[idx_q]};
          last_q <= (idx_q == '0);
        end
        default: begin
          char_q <= CH_SPACE;
          last_q <= 1'b0;
        end
      endcase
    end
  end

  assign status_o.pad_zero   = (pad_q == '0);
  assign status_o.neg        = neg_q;
  assign status_o.digit_last = (idx_q == '0);

  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

>>> rtl/core/sitd_ctrl.sv
// Controller: sequences conversion, measuring and character output.
module sitd_ctrl
  import sitd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // The output register can take a character when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    cmd_o.sel   = SEL_SPACE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
          state_d = ST_MEASURE;
        end
      end
      ST_MEASURE: begin
        cmd_o.measure = 1'b1;
        state_d       = ST_PAD;
      end
      ST_PAD: begin
        if (status_i.pad_zero) begin
          state_d = status_i.neg ? ST_SIGN : ST_DIGIT;
        end else if (out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_SPACE;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_MINUS;
          state_d    = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_DIGIT;
          if (status_i.digit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid flag follows loads and drains.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/sitd_checker.sv
// Port-level assertions for the converter and their bind to the top level.
module sitd_checker
  import sitd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // A run always ends on a digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |->
      m_axis_tdata_o >= CH_ZERO && m_axis_tdata_o <= CH_NINE)
    else $error("run does not end on a digit");

  // Only spaces, minus signs and digits are emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o == CH_SPACE || m_axis_tdata_o == CH_MINUS ||
      (m_axis_tdata_o >= CH_ZERO && m_axis_tdata_o <= CH_NINE))
    else $error("unexpected character code");

  // Conversion starts right after a request is taken, so ready drops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready stayed high after a request");

  // A stalled character holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output changed");

endmodule

bind signed_int_to_decimal_text_top sitd_checker u_sitd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);
